@@ sv/fud_pkg.sv @@
package fud_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] PAIR_NONE    = 2'd0;
    localparam logic [1:0] PAIR_KEPT    = 2'd1;
    localparam logic [1:0] PAIR_DROPPED = 2'd2;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic       value_phase;
        logic [1:0] escape_step;
        logic [7:0] held_digit;
        logic       segment_started;
    } state_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       in_value;
        logic [1:0] pair_status;
        logic       out_last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] items;
        logic [2:0]         cnt;
    } res_list_t;

endpackage

@@ sv/fud_expand.sv @@
module fud_expand
    import fud_pkg::*;
(
    input  state_t    cur_state,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output state_t    nxt_state,
    output res_list_t res_list
);

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return c[3:0];
        else
            return c[3:0] + 4'd9;
    endfunction

    // append one beat; the list never holds more than four
    function automatic res_list_t push(input res_list_t l, input logic [7:0] ch,
                                       input logic vld, input logic inval,
                                       input logic [1:0] status);
        res_list_t r;
        r = l;
        if (l.cnt < 3'(MAX_RES))
        begin
            r.items[l.cnt[1:0]].out_char    = vld ? ch : 8'h00;
            r.items[l.cnt[1:0]].char_valid  = vld;
            r.items[l.cnt[1:0]].in_value    = inval;
            r.items[l.cnt[1:0]].pair_status = status;
            r.items[l.cnt[1:0]].out_last    = 1'b0;
            r.cnt = l.cnt + 3'd1;
        end
        return r;
    endfunction

    always_comb
    begin : expand
        logic       vp;
        logic [1:0] es;
        logic [7:0] hd;
        logic       ss;
        logic       do_plain;
        logic       do_close;
        logic [7:0] c;
        res_list_t  l;

        vp = cur_state.value_phase;
        es = cur_state.escape_step;
        hd = cur_state.held_digit;
        ss = cur_state.segment_started;
        do_plain = 1'b0;
        do_close = 1'b0;
        l = '0;
        c = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

        if (es == ESC_PCT || es == ESC_DIGIT)
        begin
            if (is_hex(in_byte) && es == ESC_PCT)
            begin
                hd = in_byte;
                es = ESC_DIGIT;
            end
            else if (is_hex(in_byte))
            begin
                l = push(l, {hex_val(hd), hex_val(in_byte)}, 1'b1, 1'b1, PAIR_NONE);
                es = ESC_NONE;
                hd = 8'h00;
            end
            else
            begin
                // broken escape: pass it through, then treat the byte afresh
                l = push(l, CH_PCT, 1'b1, 1'b1, PAIR_NONE);
                if (es == ESC_DIGIT)
                    l = push(l, hd, 1'b1, 1'b1, PAIR_NONE);
                es = ESC_NONE;
                hd = 8'h00;
                do_plain = 1'b1;
            end
        end
        else
        begin
            es = ESC_NONE;
            do_plain = 1'b1;
        end

        if (do_plain)
        begin
            if (in_byte == CH_AMP)
                do_close = 1'b1;
            else
            begin
                ss = 1'b1;
                if (!vp)
                begin
                    if (in_byte == CH_EQ)
                        vp = 1'b1;
                    else
                        l = push(l, c, 1'b1, 1'b0, PAIR_NONE);
                end
                else if (in_byte == CH_PCT)
                    es = ESC_PCT;
                else
                    l = push(l, c, 1'b1, 1'b1, PAIR_NONE);
            end
        end

        // an ampersand closes first; end of body then closes any segment still open
        if (do_close)
        begin
            if (ss)
                l = push(l, 8'h00, 1'b0, vp, vp ? PAIR_KEPT : PAIR_DROPPED);
            vp = 1'b0;
            ss = 1'b0;
        end

        if (in_last)
        begin
            if (es == ESC_PCT || es == ESC_DIGIT)
                l = push(l, CH_PCT, 1'b1, 1'b1, PAIR_NONE);
            if (es == ESC_DIGIT)
                l = push(l, hd, 1'b1, 1'b1, PAIR_NONE);
            es = ESC_NONE;
            hd = 8'h00;
            if (ss)
                l = push(l, 8'h00, 1'b0, vp, vp ? PAIR_KEPT : PAIR_DROPPED);
            vp = 1'b0;
            ss = 1'b0;
        end

        if (l.cnt == 3'd0)
            l = push(l, 8'h00, 1'b0, vp, PAIR_NONE);
        l.items[2'(l.cnt - 3'd1)].out_last = 1'b1;

        res_list                  = l;
        nxt_state.value_phase     = vp;
        nxt_state.escape_step     = es;
        nxt_state.held_digit      = hd;
        nxt_state.segment_started = ss;
    end

endmodule

@@ sv/fud_outbuf.sv @@
module fud_outbuf
    import fud_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_list_t load_list,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    res_t [MAX_RES-1:0] items_reg;
    logic [2:0]         rem_reg;
    logic [2:0]         rem_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic               drain;

    assign out_valid = (rem_reg != 3'd0);
    assign out_res   = items_reg[idx_reg];
    assign drain     = out_valid && out_ready;
    // take the next list once the last beat of this one leaves
    assign can_load  = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ready);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = load_list.cnt;
            idx_next = 2'd0;
        end
        else if (drain)
        begin
            rem_next = rem_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= load_list.items;
    end

endmodule

@@ sv/form_urlencoded_decoder_core.sv @@
// Streaming decoder for a form-urlencoded body, one byte per input beat. An
// ampersand ends a pair, the first equals sign splits key from value, a plus
// becomes a space, and percent plus two hex digits decodes to one byte in the
// value only; a broken escape passes through literally. Each input byte yields
// one to four output beats (decoded bytes, pair-close markers, or one idle beat)
// and tlast marks the final beat of each byte. The output buffer drains one beat
// per cycle while m_axis_tready is high, and the next byte waits in s_axis until
// the last beat of the current byte leaves.
module form_urlencoded_decoder_core
    import fud_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [3:0] m_axis_tuser,   // [0] char_valid, [1] in_value, [3:2] pair_status
    output logic       m_axis_tlast
);

    state_t    state_reg;
    state_t    state_next;
    res_list_t res_list;
    res_t      out_res;
    logic      accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    fud_expand u_expand (
        .cur_state (state_reg),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .nxt_state (state_next),
        .res_list  (res_list)
    );

    fud_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_list (res_list),
        .can_load  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    assign m_axis_tdata = out_res.out_char;
    assign m_axis_tuser = {out_res.pair_status, out_res.in_value, out_res.char_valid};
    assign m_axis_tlast = out_res.out_last;

endmodule

@@ tb/form_urlencoded_decoder_core_tb.sv @@
module form_urlencoded_decoder_core_tb;
    import fud_pkg::*;

    localparam int RANDOM_BYTES = 260;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain_first;
    } form_byte_t;

    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic       m_axis_tlast;

    form_byte_t body_q[$];      // bytes waiting to be sent
    logic [7:0] text_q[$];      // body under construction
    res_t       decoded_q[$];   // decoded beats still to arrive
    res_t       step_beats[$];  // beats caused by the current byte

    // shadow of the decoder state
    logic       sh_value = 1'b0;
    logic [1:0] sh_escape = ESC_NONE;
    logic [7:0] sh_digit = 8'h00;
    logic       sh_started = 1'b0;

    int err_cnt = 0;
    int beats_seen = 0;
    int bytes_sent = 0;
    int bodies = 0;
    int pairs_kept = 0;
    int pairs_dropped = 0;
    int escapes_decoded = 0;

    logic     in_taken = 1'b0;
    int       burst_left = 8;
    int       gap_left = 0;
    int       ready_window = 0;
    rx_mode_t ready_mode = RX_STEADY;
    int       stall_run = 0;
    logic     stall_level = 1'b1;

    form_urlencoded_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- decoder prediction

    function automatic logic is_hex_digit(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39)
            t = c - 8'h30;
        else if (c <= 8'h46)
            t = c - 8'h37;
        else
            t = c - 8'h57;
        return t[3:0];
    endfunction

    function automatic void put_beat(logic [7:0] ch, logic valid, logic phase,
                                     logic [1:0] status);
        res_t r;
        if (step_beats.size() >= MAX_RES)
            return;
        r.out_char    = valid ? ch : 8'h00;
        r.char_valid  = valid;
        r.in_value    = phase;
        r.pair_status = status;
        r.out_last    = 1'b0;
        step_beats = {step_beats, r};
    endfunction

    // emit a pending percent and held digit as literal bytes
    function automatic void flush_escape();
        if (sh_escape != ESC_NONE)
            put_beat(CH_PCT, 1'b1, 1'b1, PAIR_NONE);
        if (sh_escape == ESC_DIGIT)
            put_beat(sh_digit, 1'b1, 1'b1, PAIR_NONE);
        sh_escape = ESC_NONE;
        sh_digit  = 8'h00;
    endfunction

    function automatic void close_pair();
        flush_escape();
        if (sh_started)
        begin
            put_beat(8'h00, 1'b0, sh_value, sh_value ? PAIR_KEPT : PAIR_DROPPED);
            if (sh_value)
                pairs_kept++;
            else
                pairs_dropped++;
        end
        sh_value   = 1'b0;
        sh_started = 1'b0;
    endfunction

    function automatic void decode_plain(logic [7:0] b);
        logic [7:0] c;
        c = (b == CH_PLUS) ? CH_SPACE : b;
        if (b == CH_AMP)
            close_pair();
        else
        begin
            sh_started = 1'b1;
            if (!sh_value)
            begin
                if (b == CH_EQ)
                    sh_value = 1'b1;
                else
                    put_beat(c, 1'b1, 1'b0, PAIR_NONE);
            end
            else if (b == CH_PCT)
                sh_escape = ESC_PCT;
            else
                put_beat(c, 1'b1, 1'b1, PAIR_NONE);
        end
    endfunction

    function automatic void decode_form_byte(logic [7:0] b, logic last);
        logic [7:0] v;
        step_beats.delete();
        if (sh_escape != ESC_NONE && is_hex_digit(b))
        begin
            if (sh_escape == ESC_PCT)
            begin
                sh_digit  = b;
                sh_escape = ESC_DIGIT;
            end
            else
            begin
                v = {hex_nibble(sh_digit), hex_nibble(b)};
                sh_escape = ESC_NONE;
                sh_digit  = 8'h00;
                put_beat(v, 1'b1, 1'b1, PAIR_NONE);
                escapes_decoded++;
            end
        end
        else
        begin
            flush_escape();
            decode_plain(b);
        end
        if (last)
            close_pair();
        if (step_beats.size() == 0)
            put_beat(8'h00, 1'b0, sh_value, PAIR_NONE);
        step_beats[step_beats.size()-1].out_last = 1'b1;
        decoded_q = {decoded_q, step_beats};
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // ---------------------------------------------------------------- body generation

    function automatic void add_byte(logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 5));
            default: return 8'h61 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] pick_nonhex();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex_digit(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 4))
            0, 1:    return 8'h61 + 8'($urandom_range(0, 25));
            2:       return 8'h41 + 8'($urandom_range(0, 25));
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic void add_str(string s);
        foreach (s[i])
            add_byte(s[i]);
    endfunction

    function automatic void add_value_token();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: add_byte(pick_text());
            4:          add_byte(CH_PLUS);
            5, 6:
            begin
                add_byte(CH_PCT);
                add_byte(pick_hex());
                add_byte(pick_hex());
            end
            7:
            begin
                add_byte(CH_PCT);
                add_byte(pick_nonhex());
            end
            8:
            begin
                add_byte(CH_PCT);
                add_byte(pick_hex());
                add_byte(pick_nonhex());
            end
            9:          add_byte(CH_EQ);
            10:         add_byte(CH_PCT);
            default:
            begin
                add_byte(CH_PCT);
                add_byte(pick_hex());
            end
        endcase
    endfunction

    function automatic void build_form();
        int pairs;
        pairs = $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0)
            add_byte(CH_AMP);
        for (int p = 0; p < pairs; p++)
        begin
            if (p > 0)
            begin
                add_byte(CH_AMP);
                if ($urandom_range(0, 6) == 0)
                    add_byte(CH_AMP);
            end
            repeat ($urandom_range(0, 4))
            begin
                case ($urandom_range(0, 9))
                    0:       add_byte(CH_PLUS);
                    1:       add_byte(CH_PCT);
                    default: add_byte(pick_text());
                endcase
            end
            if ($urandom_range(0, 4) != 0)
            begin
                add_byte(CH_EQ);
                repeat ($urandom_range(0, 5))
                    add_value_token();
            end
        end
        if ($urandom_range(0, 6) == 0)
            add_byte(CH_AMP);
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 5))
                0:       add_byte(CH_AMP);
                1:       add_byte(CH_EQ);
                2:       add_byte(CH_PCT);
                3:       add_byte(CH_PLUS);
                4:       add_byte(pick_hex());
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // move the built body to the send queue, tlast on its final byte
    function automatic void queue_body(logic drain);
        form_byte_t it;
        if (text_q.size() == 0)
            add_byte(pick_text());
        foreach (text_q[i])
        begin
            it.data        = text_q[i];
            it.last        = (i == text_q.size() - 1);
            it.drain_first = drain && (i == 0);
            body_q = {body_q, it};
        end
        text_q.delete();
        bodies++;
    endfunction

    // ---------------------------------------------------------------- driver and monitor

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (body_q.size() == 0 || (body_q[0].drain_first && decoded_q.size() != 0))
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= body_q[0].data;
                s_axis_tlast  <= body_q[0].last;
                void'(body_q.pop_front());
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_window == 0)
        begin
            ready_mode   = rx_mode_t'($urandom_range(0, 2));
            ready_window = $urandom_range(16, 160);
        end
        else
            ready_window--;
        case (ready_mode)
            RX_STEADY: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 9) >= 3);
            default:
            begin
                if (stall_run == 0)
                begin
                    stall_level = ~stall_level;
                    stall_run   = $urandom_range(1, 8);
                end
                stall_run--;
                m_axis_tready <= stall_level;
            end
        endcase
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            // predict first; a byte's beats come out of the registered buffer only after it is taken
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_form_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_seen++;
                if (decoded_q.size() == 0)
                begin
                    $error("output beat with nothing expected: tdata %0h tuser %0h tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("out_char", want.out_char, m_axis_tdata);
                    check_field("char_valid", 8'(want.char_valid), 8'(m_axis_tuser[0]));
                    check_field("in_value", 8'(want.in_value), 8'(m_axis_tuser[1]));
                    check_field("pair_status", 8'(want.pair_status), 8'(m_axis_tuser[3:2]));
                    check_field("out_last", 8'(want.out_last), 8'(m_axis_tlast));
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int directed_len;
        int guard;

        // plus in the key, upper and lower case escapes, kept pair
        add_str("+=%4A%6f&");
        // percent in key, equals in value, escape broken after percent and after digit
        add_str("%==%G%4&");
        // empty segment, extreme bytes in a dropped pair, lone equals sign
        add_str("&");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_str("&=&");
        // end of body right after a broken escape
        add_str("v=%4z");
        queue_body(1'b0);
        directed_len = body_q.size();

        while (body_q.size() - directed_len < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 99) < 85)
                build_form();
            else
                build_noise();
            queue_body(bodies % 6 == 1);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (body_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        guard = 0;
        while (decoded_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (decoded_q.size() != 0)
        begin
            $error("%0d expected output beats never arrived", decoded_q.size());
            err_cnt++;
        end

        $display("Sent %0d form bytes in %0d bodies, checked %0d output beats",
                 bytes_sent, bodies, beats_seen);
        $display("Pairs kept %0d, pairs dropped %0d, escapes decoded %0d",
                 pairs_kept, pairs_dropped, escapes_decoded);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
